/* design/cfd_pkg.sv */
// Shared types and constants for the COBS frame decoder and verifier.
`timescale 1ns / 1ps

package cfd_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] WIRE_MIN  = CNT_W'(2);
  localparam logic [CNT_W-1:0] WIRE_MAX  = CNT_W'(FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] WIRE_SAT  = CNT_W'(FRAME_BYTES + 3);

  localparam logic [7:0] CODE_NO_ZERO = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CORRUPT   = 2'd1;
  localparam logic [1:0] ST_ZERO_LEAK = 2'd2;
  localparam logic [1:0] ST_SYNC      = 2'd3;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] source_node;
    logic [63:0] step_count;
    logic [7:0]  phase;
    logic [63:0] board_word_0;
    logic [63:0] board_word_1;
    logic [63:0] board_word_2;
    logic [63:0] board_word_3;
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
  } out_t;

  // Per-frame decoder state.
  typedef struct packed {
    logic [CNT_W-1:0] stored_count;
    logic [7:0]       block_left;
    logic             zero_pending;
    logic [CNT_W-1:0] wire_count;
    logic [1:0]       first_error;
  } dec_state_t;

  // One write into the frame store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

/* design/cobs_frame_decoder_verify.sv */
// Top level of the COBS frame decoder and verifier.
//
//   Port group   Direction  Transfer when           Carries
//   in_*         input      in_valid & !in_stall    one wire byte, last-byte mark
//   out_*        output     out_valid & !out_stall  status and decoded frame fields
//   cfg_*        input      cfg_wr_en               local step count (64 bits)
//
// Each byte is registered, then decoded; one byte per cycle while no stalled result holds a last byte.
// The frame's last byte passes the input register, then its result is registered for output.
// Reset clears the handshake and frame state and the local step count; the store is not cleared.
// A stalled result holds the last byte of the next frame in the input register,
// while ordinary bytes keep flowing under output stall.
`timescale 1ns / 1ps

module cobs_frame_decoder_verify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cfd_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [63:0]   cfg_wr_data
);

  logic                s1_valid_r, s1_valid_nxt;
  cfd_pkg::in_t        s1_data_r;
  cfd_pkg::dec_state_t st_r, st_nxt;
  cfd_pkg::store_wr_t  wr;
  logic [7:0]          store_r [cfd_pkg::FRAME_BYTES];
  logic [63:0]         local_step_r;
  logic                out_valid_r, out_valid_nxt;
  cfd_pkg::out_t       out_data_r, result;
  logic [1:0]          status;
  logic [63:0]         rx_step;
  logic                advance;
  logic                in_xfer;

  assign advance   = s1_valid_r && !(s1_data_r.last_byte && out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rx_step[8*i +: 8] = store_r[4 + i];
    end
  end

  cfd_decode u_decode (
    .st               (st_r),
    .item             (s1_data_r),
    .rx_step_count    (rx_step),
    .local_step_count (local_step_r),
    .st_nxt           (st_nxt),
    .wr               (wr),
    .status           (status)
  );

  // Assemble the result; every field but status stays zero unless the frame is good.
  always_comb begin
    result        = '0;
    result.status = status;
    if (status == cfd_pkg::ST_OK) begin
      for (int i = 0; i < 4; i++) begin
        result.source_node[8*i +: 8] = store_r[i];
      end
      result.step_count = rx_step;
      result.phase      = store_r[12];
      for (int i = 0; i < 8; i++) begin
        result.board_word_0[8*i +: 8]  = store_r[16 + i];
        result.board_word_1[8*i +: 8]  = store_r[24 + i];
        result.board_word_2[8*i +: 8]  = store_r[32 + i];
        result.board_word_3[8*i +: 8]  = store_r[40 + i];
        result.digest_word_0[8*i +: 8] = store_r[48 + i];
        result.digest_word_1[8*i +: 8] = store_r[56 + i];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_data_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
      local_step_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        local_step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_data_r.last_byte) begin
      out_data_r <= result;
    end
    if (advance && wr.en) begin
      store_r[wr.addr] <= wr.data;
    end
  end

  // A result only follows the decode of a last byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && s1_data_r.last_byte))
    else $error("result without a last byte");

  // Source node, step count, phase and the second digest word are zero on any failed frame.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != cfd_pkg::ST_OK)) |->
      ((out_data_r.source_node == '0) && (out_data_r.step_count == '0) &&
       (out_data_r.phase == '0) && (out_data_r.digest_word_1 == '0)))
    else $error("nonzero fields on failed frame");

  // The decoder never writes past the store.
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stored_count <= cfd_pkg::FRAME_CNT)
    else $error("stored count beyond frame size");

  // Frame state is cleared after the last byte.
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data_r.last_byte) |=>
      ((st_r.stored_count == '0) && (st_r.wire_count == '0) &&
       (st_r.first_error == cfd_pkg::ST_OK)))
    else $error("frame state not cleared");

endmodule

/* design/cfd_decode.sv */
// Next-state logic for one wire byte: COBS decode step and end-of-frame checks.
`timescale 1ns / 1ps

module cfd_decode (
  input  cfd_pkg::dec_state_t st,
  input  cfd_pkg::in_t        item,
  input  logic [63:0]         rx_step_count,
  input  logic [63:0]         local_step_count,
  output cfd_pkg::dec_state_t st_nxt,
  output cfd_pkg::store_wr_t  wr,
  output logic [1:0]          status
);

  logic [cfd_pkg::CNT_W-1:0] wire_cnt;
  logic                      store_full;

  assign store_full = (st.stored_count >= cfd_pkg::FRAME_CNT);

  always_comb begin
    wire_cnt = (st.wire_count < cfd_pkg::WIRE_SAT) ? st.wire_count + 1'b1 : st.wire_count;
  end

  always_comb begin
    st_nxt            = st;
    st_nxt.wire_count = wire_cnt;
    wr.en             = 1'b0;
    wr.addr           = st.stored_count[cfd_pkg::IDX_W-1:0];
    wr.data           = cfd_pkg::BYTE_ZERO;
    status            = cfd_pkg::ST_OK;

    if (item.last_byte) begin
      if ((wire_cnt < cfd_pkg::WIRE_MIN) || (wire_cnt > cfd_pkg::WIRE_MAX) ||
          (item.wire_byte != cfd_pkg::BYTE_ZERO)) begin
        status = cfd_pkg::ST_CORRUPT;
      end else if (st.first_error != cfd_pkg::ST_OK) begin
        status = st.first_error;
      end else if ((st.block_left != 8'd0) || (st.stored_count != cfd_pkg::FRAME_CNT)) begin
        status = cfd_pkg::ST_CORRUPT;
      end else if (rx_step_count != local_step_count) begin
        status = cfd_pkg::ST_SYNC;
      end
      // The frame is finished; start the next one from scratch.
      st_nxt = '0;
    end else if (st.first_error == cfd_pkg::ST_OK) begin
      if (st.block_left == 8'd0) begin
        // Code byte. The implied zero of the previous block lands first.
        if (st.zero_pending && store_full) begin
          st_nxt.first_error = cfd_pkg::ST_CORRUPT;
        end else begin
          if (st.zero_pending) begin
            wr.en               = 1'b1;
            st_nxt.stored_count = st.stored_count + 1'b1;
          end
          if (item.wire_byte == cfd_pkg::BYTE_ZERO) begin
            st_nxt.first_error = cfd_pkg::ST_ZERO_LEAK;
          end else begin
            st_nxt.block_left   = item.wire_byte - 8'd1;
            st_nxt.zero_pending = (item.wire_byte != cfd_pkg::CODE_NO_ZERO);
          end
        end
      end else begin
        if (store_full) begin
          st_nxt.first_error = cfd_pkg::ST_CORRUPT;
        end else if (item.wire_byte == cfd_pkg::BYTE_ZERO) begin
          st_nxt.first_error = cfd_pkg::ST_ZERO_LEAK;
        end else begin
          wr.en               = 1'b1;
          wr.data             = item.wire_byte;
          st_nxt.stored_count = st.stored_count + 1'b1;
          st_nxt.block_left   = st.block_left - 8'd1;
        end
      end
    end
  end

endmodule
